>>> src/dpke_pkg.sv
// ----------------------------------------------------------------------------
// dpke_pkg
// Shared types and constants of the debounced pedal key encoder.
// ----------------------------------------------------------------------------
package dpke_pkg;

    // Widths fixed by the pin and keycode fields
    localparam int PIN_W       = 5;
    localparam int CODE_W      = 8;
    localparam int TICKS_W     = 16;
    localparam int NUM_CODES   = 5;
    localparam int MAX_BUTTONS = 8;
    localparam int BTN_IDX_W   = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_PLAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_FORWARD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_BACK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_SPEED   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_LOOP    = 3'd5;

    // Reset values
    localparam logic [TICKS_W-1:0] DEBOUNCE_RESET     = 16'd50;
    localparam logic [CODE_W-1:0]  CODE_PLAY_RESET    = 8'd81;  // 'Q'
    localparam logic [CODE_W-1:0]  CODE_FORWARD_RESET = 8'd85;  // 'U'
    localparam logic [CODE_W-1:0]  CODE_BACK_RESET    = 8'd69;  // 'E'
    localparam logic [CODE_W-1:0]  CODE_SPEED_RESET   = 8'd82;  // 'R'
    localparam logic [CODE_W-1:0]  CODE_LOOP_RESET    = 8'd84;  // 'T'

    typedef logic [NUM_CODES-1:0][CODE_W-1:0] code_array_t;

    // One run of key emissions handed from the debouncer to the emitter
    typedef struct packed {
        logic                   valid;
        logic [MAX_BUTTONS-1:0] mask;
        logic                   led;
    } run_t;

endpackage

>>> src/debounced_pedal_key_encoder.sv
// ----------------------------------------------------------------------------
// debounced_pedal_key_encoder
// Debounces five active-low pedal inputs and emits a keycode for each newly
// pressed pedal, toggling an LED level on every key.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while in_stall is low; a run holds the
//   emitter, one key per cycle while out_stall is low, and a further run
//   waits behind it.
// Reset: counter, patterns and queues clear, LED level starts high, debounce
//   and keycode registers take their default values.
// ----------------------------------------------------------------------------
module debounced_pedal_key_encoder
    import dpke_pkg::*;
#(
    parameter int BUTTON_COUNT = 5,
    parameter int COUNT_WIDTH  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIN_W-1:0]      pin_levels,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CODE_W-1:0]     key_code,
    output logic                  led_level,
    output logic                  last
);

    logic [TICKS_W-1:0] debounce_reg;
    code_array_t        codes_reg;
    run_t               run;
    logic               run_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            codes_reg[0] <= CODE_PLAY_RESET;
            codes_reg[1] <= CODE_FORWARD_RESET;
            codes_reg[2] <= CODE_BACK_RESET;
            codes_reg[3] <= CODE_SPEED_RESET;
            codes_reg[4] <= CODE_LOOP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE:     debounce_reg <= cfg_data;
                REG_CODE_PLAY:    codes_reg[0] <= cfg_data[CODE_W-1:0];
                REG_CODE_FORWARD: codes_reg[1] <= cfg_data[CODE_W-1:0];
                REG_CODE_BACK:    codes_reg[2] <= cfg_data[CODE_W-1:0];
                REG_CODE_SPEED:   codes_reg[3] <= cfg_data[CODE_W-1:0];
                REG_CODE_LOOP:    codes_reg[4] <= cfg_data[CODE_W-1:0];
                default:          ;  // drop writes beyond the register list
            endcase
        end
    end

    dpke_debounce #(
        .BUTTON_COUNT (BUTTON_COUNT),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_debounce (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pin_levels     (pin_levels),
        .debounce_ticks (debounce_reg),
        .run_ready      (run_ready),
        .run            (run)
    );

    dpke_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .run       (run),
        .run_ready (run_ready),
        .codes     (codes_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .key_code  (key_code),
        .led_level (led_level),
        .last      (last)
    );

endmodule

>>> src/dpke_debounce.sv
// ----------------------------------------------------------------------------
// dpke_debounce
// Input register, stable-tick counter and accepted pattern; produces a run
// of newly pressed buttons for the emitter.
// ----------------------------------------------------------------------------
module dpke_debounce
    import dpke_pkg::*;
#(
    parameter int BUTTON_COUNT = 5,
    parameter int COUNT_WIDTH  = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [PIN_W-1:0]   pin_levels,
    input  logic [TICKS_W-1:0] debounce_ticks,
    input  logic               run_ready,
    output run_t               run
);

    localparam int CMP_W = (COUNT_WIDTH > TICKS_W) ? COUNT_WIDTH : TICKS_W;

    logic                    in_v_reg;
    logic [PIN_W-1:0]        pin_reg;
    logic [BUTTON_COUNT-1:0] prev_reg, prev_next;
    logic [COUNT_WIDTH-1:0]  count_reg, count_next;
    logic [BUTTON_COUNT-1:0] accepted_reg, accepted_next;
    logic                    led_reg, led_next;

    logic [BUTTON_COUNT-1:0] sample;
    logic [BUTTON_COUNT-1:0] fresh;
    logic                    take;
    logic                    proc;

    always_comb
    begin
        // Pins above the field width read as driven low, i.e. pressed
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            if (i < PIN_W)
                sample[i] = ~pin_reg[i];
            else
                sample[i] = 1'b1;
        end

        if (sample != prev_reg)
            count_next = '0;
        else if (count_reg != {COUNT_WIDTH{1'b1}})
            count_next = count_reg + 1'b1;
        else
            count_next = count_reg;

        take  = (CMP_W'(count_next) > CMP_W'(debounce_ticks)) && (sample != accepted_reg);
        fresh = take ? (sample & ~accepted_reg) : '0;

        // Hold an item that starts a new run while the previous run is still being emitted
        proc     = in_v_reg && ((fresh == '0) || run_ready);
        in_stall = in_v_reg && !proc;

        run.valid = proc && (fresh != '0);
        run.mask  = MAX_BUTTONS'(fresh);
        run.led   = led_reg;

        prev_next     = prev_reg;
        accepted_next = accepted_reg;
        led_next      = led_reg;
        if (proc)
        begin
            prev_next = sample;
            if (take)
            begin
                accepted_next = sample;
                led_next      = led_reg ^ (^fresh);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg     <= 1'b0;
            prev_reg     <= '0;
            count_reg    <= '0;
            accepted_reg <= '0;
            led_reg      <= 1'b1;
        end
        else
        begin
            if (!in_stall)
                in_v_reg <= in_valid;
            if (proc)
                count_reg <= count_next;
            prev_reg     <= prev_next;
            accepted_reg <= accepted_next;
            led_reg      <= led_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            pin_reg <= pin_levels;
    end

endmodule

>>> src/dpke_emitter.sv
// ----------------------------------------------------------------------------
// dpke_emitter
// Walks a run of newly pressed buttons in bit order, one keycode per cycle
// while out_stall allows, into the result register.
// ----------------------------------------------------------------------------
module dpke_emitter
    import dpke_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  run_t              run,
    output logic              run_ready,
    input  code_array_t       codes,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CODE_W-1:0] key_code,
    output logic              led_level,
    output logic              last
);

    logic                   pend_v_reg;
    logic [MAX_BUTTONS-1:0] pend_mask_reg;
    logic                   pend_led_reg;
    logic                   out_v_reg;
    logic [CODE_W-1:0]      code_reg;
    logic                   led_out_reg;
    logic                   last_reg;

    logic                   emit;
    logic [BTN_IDX_W-1:0]   idx;
    logic [MAX_BUTTONS-1:0] rest;
    logic [CODE_W-1:0]      code_sel;
    logic                   led_cur;

    always_comb
    begin
        idx = '0;
        for (int i = MAX_BUTTONS - 1; i >= 0; i--)
        begin
            if (pend_mask_reg[i])
                idx = BTN_IDX_W'(i);
        end
        rest     = pend_mask_reg & (pend_mask_reg - 1'b1);
        code_sel = (32'(idx) < NUM_CODES) ? codes[idx] : '0;
        led_cur  = ~pend_led_reg;

        emit      = pend_v_reg && (!out_v_reg || !out_stall);
        run_ready = !pend_v_reg || (emit && (rest == '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (run.valid)
                pend_v_reg <= 1'b1;
            else if (emit && (rest == '0))
                pend_v_reg <= 1'b0;

            if (emit)
                out_v_reg <= 1'b1;
            else if (!out_stall)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        // Load a new run, otherwise advance through the current one
        if (run.valid)
        begin
            pend_mask_reg <= run.mask;
            pend_led_reg  <= run.led;
        end
        else if (emit)
        begin
            pend_mask_reg <= rest;
            pend_led_reg  <= led_cur;
        end

        if (emit)
        begin
            code_reg    <= code_sel;
            led_out_reg <= led_cur;
            last_reg    <= (rest == '0);
        end
    end

    assign out_valid = out_v_reg;
    assign key_code  = code_reg;
    assign led_level = led_out_reg;
    assign last      = last_reg;

endmodule
